// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the sieve block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define OPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define OPS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ops_pkg.sv
// ---------------------------------------------------------------------------
// ops_pkg
// Widths, types and the controller/datapath interface of the sieve block.
// ---------------------------------------------------------------------------
package ops_pkg;

	localparam int MAX_NUMBERS = 65536;
	localparam int LIMIT_W     = 17;
	localparam int QUERY_W     = 16;
	localparam int COUNT_W     = 16;

	// Only odd numbers are stored: entry k stands for 2k+1.
	localparam int DEPTH    = MAX_NUMBERS / 2;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int IDX_W    = ADDR_W + 1;

	// Digit-by-digit square root, two bits of the radicand per step.
	localparam int SQ_STEPS = (LIMIT_W + 1) / 2;
	localparam int SQ_CNT_W = $clog2(SQ_STEPS);
	localparam int ROOT_W   = SQ_STEPS;
	localparam int F_W      = ROOT_W + 1;
	localparam int M_W      = 2 * F_W;

	typedef logic [LIMIT_W-1:0]  limit_t;
	typedef logic [QUERY_W-1:0]  query_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [SQ_CNT_W-1:0] sq_cnt_t;
	typedef logic [ROOT_W-1:0]   root_t;
	typedef logic [F_W-1:0]      f_t;
	typedef logic [M_W-1:0]      m_t;
	typedef logic [LIMIT_W:0]    sq_res_t;

	localparam bit     CAP_ABOVE_LIMIT = MAX_NUMBERS >= (2 ** LIMIT_W);
	localparam limit_t MAX_LIMIT       = limit_t'(MAX_NUMBERS);
	localparam limit_t SQ_BIT_INIT     = limit_t'(1) << (2 * (SQ_STEPS - 1));
	localparam sq_cnt_t SQ_LAST        = sq_cnt_t'(SQ_STEPS - 1);
	localparam count_t COUNT_MAX       = '1;
	localparam f_t     F_FIRST         = f_t'(3);

	typedef struct packed {
		logic q_load;      // latch the query number
		logic q_rd_port;   // read the map at the incoming query
		logic q_rd;        // read the map at the latched query
		logic sieve_init;  // preset clear address, root unit, factor, count
		logic clr_step;    // clear one entry
		logic sq_step;     // one square-root step
		logic f_rd;        // read the entry of the current factor
		logic f_next;      // advance the factor by two
		logic m_load;      // load the first multiple (factor squared)
		logic m_step;      // mark one multiple and advance
		logic cnt_issue;   // read one entry for the prime count
	} ops_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic sq_last;
		logic f_over;      // factor above the root
		logic f_skip;      // factor marked or out of range
		logic m_end;       // multiple at or above the limit
		logic cnt_more;    // more odd numbers left to count
	} ops_sts_t;

endpackage

// File: design/ops_ram.sv
// ---------------------------------------------------------------------------
// ops_ram
// Generic single-port RAM with registered, read-first read data.
// ---------------------------------------------------------------------------
module ops_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: design/ops_dp.sv
// ---------------------------------------------------------------------------
// ops_dp
// Sieve datapath: limit register, root unit, factor and multiple
// registers, prime counter and the composite map.
// ---------------------------------------------------------------------------
module ops_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ops_pkg::ops_cmd_t     cmd,
	output ops_pkg::ops_sts_t     sts,
	input  logic                  limit_we,
	input  ops_pkg::limit_t       limit_wdata,
	input  ops_pkg::query_t       query_number,
	output logic                  is_prime,
	output ops_pkg::count_t       prime_count
);

	ops_pkg::limit_t  limit_q;
	ops_pkg::limit_t  eff_lim;
	ops_pkg::query_t  q_q;
	ops_pkg::addr_t   clr_addr_q;
	ops_pkg::limit_t  sq_rem_q;
	ops_pkg::sq_res_t sq_res_q;
	ops_pkg::limit_t  sq_bit_q;
	ops_pkg::sq_cnt_t sq_cnt_q;
	ops_pkg::sq_res_t sq_sum;
	ops_pkg::root_t   root;
	ops_pkg::f_t      f_q;
	ops_pkg::m_t      m_q;
	ops_pkg::idx_t    idx_q;
	logic             cnt_vld_s1;
	ops_pkg::count_t  count_q;

	logic             ram_we;
	ops_pkg::addr_t   ram_addr;
	logic [0:0]       ram_wdata;
	logic [0:0]       ram_rdata;

	// Cap the limit at the map capacity.
	always_comb begin
		eff_lim = limit_q;
		if (!ops_pkg::CAP_ABOVE_LIMIT && (limit_q > ops_pkg::MAX_LIMIT)) begin
			eff_lim = ops_pkg::MAX_LIMIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ops_pkg::limit_t'(ops_pkg::MAX_NUMBERS > 65536 ? 65536
				: ops_pkg::MAX_NUMBERS);
		end else if (limit_we) begin
			limit_q <= limit_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_s1 <= 1'b0;
		end else begin
			cnt_vld_s1 <= cmd.cnt_issue;
		end
	end

	assign sq_sum = sq_res_q + ops_pkg::sq_res_t'(sq_bit_q);
	assign root   = sq_res_q[ops_pkg::ROOT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.q_load) begin
			q_q <= query_number;
		end
		if (cmd.sieve_init) begin
			clr_addr_q <= '0;
			sq_rem_q   <= eff_lim;
			sq_res_q   <= '0;
			sq_bit_q   <= ops_pkg::SQ_BIT_INIT;
			sq_cnt_q   <= '0;
			f_q        <= ops_pkg::F_FIRST;
			idx_q      <= ops_pkg::idx_t'(1);
		end else begin
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + ops_pkg::addr_t'(1);
			end
			if (cmd.sq_step) begin
				if (ops_pkg::sq_res_t'(sq_rem_q) >= sq_sum) begin
					sq_rem_q <= sq_rem_q - sq_sum[ops_pkg::LIMIT_W-1:0];
					sq_res_q <= (sq_res_q >> 1) + ops_pkg::sq_res_t'(sq_bit_q);
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
				sq_cnt_q <= sq_cnt_q + ops_pkg::sq_cnt_t'(1);
			end
			if (cmd.f_next) begin
				f_q <= f_q + ops_pkg::f_t'(2);
			end
			if (cmd.cnt_issue) begin
				idx_q <= idx_q + ops_pkg::idx_t'(1);
			end
		end
		if (cmd.m_load) begin
			m_q <= ops_pkg::m_t'(f_q) * ops_pkg::m_t'(f_q);
		end else if (cmd.m_step) begin
			m_q <= m_q + (ops_pkg::m_t'(f_q) << 1);
		end
	end

	// Count unmarked odd entries; the prime 2 is preset when it is in range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.sieve_init) begin
			count_q <= ops_pkg::count_t'(eff_lim > ops_pkg::limit_t'(2));
		end else if (cnt_vld_s1 && !ram_rdata[0] && (count_q != ops_pkg::COUNT_MAX)) begin
			count_q <= count_q + ops_pkg::count_t'(1);
		end
	end

	always_comb begin
		ram_we    = cmd.clr_step | cmd.m_step;
		ram_wdata = cmd.m_step;
		if (cmd.clr_step) begin
			ram_addr = clr_addr_q;
		end else if (cmd.m_step) begin
			ram_addr = ops_pkg::addr_t'(m_q >> 1);
		end else if (cmd.f_rd) begin
			ram_addr = ops_pkg::addr_t'(f_q >> 1);
		end else if (cmd.cnt_issue) begin
			ram_addr = idx_q[ops_pkg::ADDR_W-1:0];
		end else if (cmd.q_rd) begin
			ram_addr = ops_pkg::addr_t'(q_q >> 1);
		end else if (cmd.q_rd_port) begin
			ram_addr = ops_pkg::addr_t'(query_number >> 1);
		end else begin
			ram_addr = '0;
		end
	end

	ops_ram #(
		.WIDTH(1),
		.DEPTH(ops_pkg::DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign sts.clr_last = &clr_addr_q;
	assign sts.sq_last  = sq_cnt_q == ops_pkg::SQ_LAST;
	assign sts.f_over   = f_q > {1'b0, root};
	assign sts.f_skip   = ram_rdata[0] || (ops_pkg::m_t'(f_q) >= ops_pkg::m_t'(eff_lim));
	assign sts.m_end    = m_q >= ops_pkg::m_t'(eff_lim);
	assign sts.cnt_more = 32'({idx_q, 1'b1}) < 32'(eff_lim);

	assign is_prime    = ({1'b0, q_q} < eff_lim) &&
		((q_q == ops_pkg::query_t'(2)) ||
		 (q_q[0] && (q_q >= ops_pkg::query_t'(3)) && !ram_rdata[0]));
	assign prime_count = count_q;

endmodule

// File: design/ops_ctrl.sv
// ---------------------------------------------------------------------------
// ops_ctrl
// Sieve controller: sequences clear, root, marking, counting and lookup.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ops_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              limit_we,
	input  ops_pkg::ops_sts_t sts,
	output ops_pkg::ops_cmd_t cmd,
	output logic              busy,
	output logic              done
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_CLEAR = 10'b00_0000_0010,
		ST_SQRT  = 10'b00_0000_0100,
		ST_FREAD = 10'b00_0000_1000,
		ST_FCHK  = 10'b00_0001_0000,
		ST_MARK  = 10'b00_0010_0000,
		ST_COUNT = 10'b00_0100_0000,
		ST_DRAIN = 10'b00_1000_0000,
		ST_LOOK  = 10'b01_0000_0000,
		ST_REPLY = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_nxt;
	logic   ready_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.q_load = 1'b1;
					if (ready_q) begin
						cmd.q_rd_port = 1'b1;
						state_nxt     = ST_REPLY;
					end else begin
						cmd.sieve_init = 1'b1;
						state_nxt      = ST_CLEAR;
					end
				end
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nxt = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cmd.sq_step = 1'b1;
				if (sts.sq_last) begin
					state_nxt = ST_FREAD;
				end
			end
			ST_FREAD: begin
				if (sts.f_over) begin
					state_nxt = ST_COUNT;
				end else begin
					cmd.f_rd  = 1'b1;
					state_nxt = ST_FCHK;
				end
			end
			ST_FCHK: begin
				if (sts.f_skip) begin
					cmd.f_next = 1'b1;
					state_nxt  = ST_FREAD;
				end else begin
					cmd.m_load = 1'b1;
					state_nxt  = ST_MARK;
				end
			end
			ST_MARK: begin
				if (sts.m_end) begin
					cmd.f_next = 1'b1;
					state_nxt  = ST_FREAD;
				end else begin
					cmd.m_step = 1'b1;
				end
			end
			ST_COUNT: begin
				if (sts.cnt_more) begin
					cmd.cnt_issue = 1'b1;
				end else begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_LOOK;
			end
			ST_LOOK: begin
				cmd.q_rd  = 1'b1;
				state_nxt = ST_REPLY;
			end
			ST_REPLY: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Drop the map on a limit write; hold it once the count is complete.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else if (limit_we) begin
			ready_q <= 1'b0;
		end else if (state_q == ST_DRAIN) begin
			ready_q <= 1'b1;
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_REPLY;

	`OPS_ASSERT(a_fast_reply, start && !busy && ready_q |=> done, "ready query did not reply")
	`OPS_ASSERT(a_reply_frees, done |=> !busy, "block stayed busy after a reply")
	`OPS_ASSERT(a_write_drops, limit_we |=> !ready_q, "limit write did not drop the sieve")
	`OPS_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !busy && !done, "busy or done after reset")

endmodule

// File: design/odd_only_prime_sieve.sv
// ---------------------------------------------------------------------------
// odd_only_prime_sieve
// Odd-only sieve of Eratosthenes below a programmable limit, answering
// primality queries together with the count of primes below the limit.
// ---------------------------------------------------------------------------
//
//  channel   ports                                  handshake
//  -------   -------------------------------------  -------------------------
//  request   start, query_number                    taken when start && !busy
//  result    done, is_prime, prime_count            one-cycle strobe on done
//  config    limit_we, limit_wdata                  written when limit_we
//
//  A request against a built sieve is accepted, reads the map through one
//  registered read, then replies on done; busy is high in the reply cycle.
//  The first request after reset or a limit write builds the sieve first:
//  a clearing pass over all DEPTH (32768) entries, 9 root steps, a read and
//  a check per odd factor up to the root, one map write per multiple of each
//  marking factor plus a closing step, a counting pass over the odd entries
//  below the limit, then drain, lookup and reply. Clearing, factor reads,
//  marking, counting and lookup share the single port of the composite map,
//  which sets their length. Reset is asynchronous and leaves the sieve
//  unbuilt. Results cannot be stalled; prime_count holds between requests.
// ---------------------------------------------------------------------------
module odd_only_prime_sieve (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ops_pkg::query_t query_number,
	output logic            done,
	output logic            is_prime,
	output ops_pkg::count_t prime_count,
	input  logic            limit_we,
	input  ops_pkg::limit_t limit_wdata
);

	// Commands from the controller, status back from the datapath.
	ops_pkg::ops_cmd_t cmd;
	ops_pkg::ops_sts_t sts;

	// Sequence the request: build the sieve when needed, then look up.
	ops_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.limit_we(limit_we),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	// Hold the limit, the composite map and the prime count.
	ops_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.limit_we    (limit_we),
		.limit_wdata (limit_wdata),
		.query_number(query_number),
		.is_prime    (is_prime),
		.prime_count (prime_count)
	);

endmodule
